@@ rtl/pcsum_pkg.sv @@
package pcsum_pkg;

    localparam int SUM_W  = 64;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 3;
    localparam int FOLD_W = WORD_W + 1;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(4);

    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [FOLD_W-1:0] t_fold;

    // low half plus high half, 33 bits
    function automatic t_fold fold_once(input t_sum v);
        return {1'b0, v[WORD_W-1:0]} + {1'b0, v[SUM_W-1:WORD_W]};
    endfunction

    // amount a beat adds; short counts only matter on the last word
    function automatic t_word beat_value(input t_word word, input t_cnt cnt,
                                         input logic last);
        t_word add;
        add = '0;
        if (!last || cnt >= FULL_CNT) begin
            add = word;
        end else if (cnt[1]) begin
            add = {16'b0, word[15:0]} + (cnt[0] ? {24'b0, word[23:16]} : '0);
        end else if (cnt[0]) begin
            add = {24'b0, word[7:0]};
        end
        return add;
    endfunction

endpackage

@@ rtl/partial_checksum_accumulator.sv @@
// A last word passes the input register, then r_sum and r_chk in pcsum_fin.
// One word per cycle while o_stall is low; the running sum loop holds one register.
// Words that are not last produce no result and retire from the input register.
// Reset (i_rst_n low, synchronous) empties all stages and clears the running sum.
module partial_checksum_accumulator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  pcsum_pkg::t_word       i_data_word,
    input  pcsum_pkg::t_cnt        i_byte_count,
    input  logic                   i_first_beat,
    input  logic                   i_last_beat,
    input  pcsum_pkg::t_sum        i_seed_sum,
    output logic                   o_valid,
    input  logic                   i_stall,
    output pcsum_pkg::t_word       o_checksum
);
    import pcsum_pkg::*;

    logic  r_v_in;
    t_word r_word;
    t_cnt  r_cnt;
    logic  r_first;
    logic  r_last;
    t_fold r_seed_fold;
    t_sum  r_sum;

    logic  fin_ready;
    logic  fire;
    logic  en_in;
    t_sum  base;
    t_sum  acc;

    assign fire    = r_v_in && (!r_last || fin_ready);
    assign en_in   = !r_v_in || fire;
    assign o_stall = !en_in;

    assign base = r_first ? {{(SUM_W-FOLD_W){1'b0}}, r_seed_fold} : r_sum;
    assign acc  = base + {{(SUM_W-WORD_W){1'b0}}, beat_value(r_word, r_cnt, r_last)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in <= 1'b0;
            r_sum  <= '0;
        end else begin
            if (en_in) begin
                r_v_in <= i_valid;
            end
            if (fire) begin
                r_sum <= r_last ? '0 : acc;
            end
        end
    end

    // seed is folded on the way in to keep the accumulate path short
    always_ff @(posedge i_clk) begin
        if (en_in && i_valid) begin
            r_word      <= i_data_word;
            r_cnt       <= i_byte_count;
            r_first     <= i_first_beat;
            r_last      <= i_last_beat;
            r_seed_fold <= fold_once(i_seed_sum);
        end
    end

    pcsum_fin u_fin (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (fire && r_last),
        .i_sum      (acc),
        .o_ready    (fin_ready),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_checksum (o_checksum)
    );

`ifndef SYNTHESIS
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_last |=> r_sum == '0)
        else $error("running sum not cleared after last word");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v_in)
        else $error("input stalled with empty input register");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v_in)
        else $error("accepted word lost from input register");
`endif

endmodule

@@ rtl/pcsum_fin.sv @@
module pcsum_fin (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  pcsum_pkg::t_sum       i_sum,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_stall,
    output pcsum_pkg::t_word      o_checksum
);
    import pcsum_pkg::*;

    logic  r_v_sum;
    t_sum  r_sum;
    logic  r_v_out;
    t_word r_chk;
    logic  en_out;
    t_fold f1;
    t_word f2;

    assign en_out  = !r_v_out || !i_stall;
    assign o_ready = !r_v_sum || en_out;

    // second fold: end-around carry of the first
    assign f1 = fold_once(r_sum);
    assign f2 = f1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, f1[WORD_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sum <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v_sum <= i_valid;
            end
            if (en_out) begin
                r_v_out <= r_v_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum <= i_sum;
        end
        if (en_out && r_v_sum) begin
            r_chk <= f2;
        end
    end

    assign o_valid    = r_v_out;
    assign o_checksum = r_chk;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pcsum_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 100;
    localparam int NUM_PHASES     = 8;
    localparam int DIR_N          = 19;

    typedef struct packed {
        t_word word;
        t_cnt  cnt;
        logic  first;
        logic  last;
        t_sum  seed;
        logic  known;   // checksum typed in below
        t_word chk;
    } beat_t;

    logic   i_clk        = 1'b0;
    logic   i_rst_n      = 1'b0;
    logic   i_valid      = 1'b0;
    t_word  i_data_word  = '0;
    t_cnt   i_byte_count = '0;
    logic   i_first_beat = 1'b0;
    logic   i_last_beat  = 1'b0;
    t_sum   i_seed_sum   = '0;
    logic   i_stall      = 1'b0;
    logic   o_stall;
    logic   o_valid;
    t_word  o_checksum;

    t_sum   run_sum = '0;
    t_word  checksum_q[$];
    t_word  exp_chk;
    int     n_err        = 0;
    int     quiet_cycles = 0;
    int     idle_pct     = 0;
    int     stall_pct    = 0;

    // word, count, first, last, seed, known, checksum
    beat_t dir_tab [0:DIR_N-1] = '{
        // running sum is zero straight out of reset
        '{32'hA5A5_A5A5, 3'd4, 1'b0, 1'b1, 64'h0, 1'b1, 32'hA5A5_A5A5},
        '{32'h0000_0000, 3'd4, 1'b1, 1'b1, 64'h0, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 64'h0, 1'b1, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
        // short last words, count 0 and counts above four
        '{32'h1234_5678, 3'd1, 1'b0, 1'b1, 64'h0, 1'b1, 32'h0000_0078},
        '{32'h1234_5678, 3'd2, 1'b0, 1'b1, 64'h0, 1'b1, 32'h0000_5678},
        '{32'h1234_5678, 3'd3, 1'b0, 1'b1, 64'h0, 1'b1, 32'h0000_56AC},
        '{32'h1234_5678, 3'd0, 1'b0, 1'b1, 64'h0, 1'b1, 32'h0000_0000},
        '{32'h1234_5678, 3'd5, 1'b0, 1'b1, 64'h0, 1'b1, 32'h1234_5678},
        '{32'h1234_5678, 3'd7, 1'b0, 1'b1, 64'h0, 1'b1, 32'h1234_5678},
        // non-last words add all four bytes whatever the count
        '{32'h1111_1111, 3'd1, 1'b1, 1'b0, 64'h0000_0001_0000_0002, 1'b0, 32'h0},
        '{32'h2222_2222, 3'd6, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 64'h0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b1, 64'h0, 1'b0, 32'h0},
        // seed fold carries, then a restart in the middle of a packet
        '{32'h8000_0000, 3'd4, 1'b1, 1'b0, 64'hFFFF_FFFF_0000_0001, 1'b0, 32'h0},
        '{32'h8000_0000, 3'd4, 1'b0, 1'b0, 64'h0, 1'b0, 32'h0},
        '{32'h0000_0001, 3'd3, 1'b1, 1'b0, 64'h0000_0000_0000_0005, 1'b0, 32'h0},
        '{32'hFF00_FF00, 3'd2, 1'b0, 1'b1, 64'h0, 1'b0, 32'h0},
        '{32'hDEAD_BEEF, 3'd3, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0}
    };

    partial_checksum_accumulator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_first_beat (i_first_beat),
        .i_last_beat  (i_last_beat),
        .i_seed_sum   (i_seed_sum),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_checksum   (o_checksum)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_sum sum_halves(input t_sum v);
        return {32'd0, v[31:0]} + {32'd0, v[63:32]};
    endfunction

    function automatic t_sum word_addend(input beat_t b);
        if (!b.last || b.cnt >= FULL_CNT) begin
            return {32'd0, b.word};
        end
        if (b.cnt[1]) begin
            return {48'd0, b.word[15:0]} + (b.cnt[0] ? {56'd0, b.word[23:16]} : 64'd0);
        end
        if (b.cnt[0]) begin
            return {56'd0, b.word[7:0]};
        end
        return '0;
    endfunction

    task automatic predict_checksum(input beat_t b);
        t_sum acc;
        acc = (b.first ? sum_halves(b.seed) : run_sum) + word_addend(b);
        if (b.last) begin
            acc = sum_halves(sum_halves(acc));
            checksum_q = {checksum_q, (b.known ? b.chk : acc[31:0])};
            run_sum = '0;
        end else begin
            run_sum = acc;
        end
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_sum rand_seed();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_beat(input beat_t b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_word  <= b.word;
        i_byte_count <= b.cnt;
        i_first_beat <= b.first;
        i_last_beat  <= b.last;
        i_seed_sum   <= b.seed;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_checksum(b);
    endtask

    // hold the sender off until every checksum in flight has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (checksum_q.size() != 0);
    endtask

    task automatic run_packets(input int n_items);
        int    sent;
        int    len;
        beat_t b;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 8) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    b.word  = rand_word();
                    b.first = (k == 0);
                    b.last  = (k == len - 1);
                    b.seed  = rand_seed();
                    if (b.last) begin
                        b.cnt = ($urandom_range(3) == 0) ? t_cnt'($urandom_range(0, 7))
                                                         : t_cnt'($urandom_range(1, 4));
                    end else begin
                        b.cnt = ($urandom_range(4) == 0) ? t_cnt'($urandom_range(0, 7))
                                                         : FULL_CNT;
                    end
                    b.known = 1'b0;
                    b.chk   = '0;
                    send_beat(b);
                end
                sent += len;
            end else begin
                // stray word: flags, count and seed all random
                b.word  = rand_word();
                b.cnt   = t_cnt'($urandom_range(0, 7));
                b.first = 1'($urandom_range(1));
                b.last  = 1'($urandom_range(1));
                b.seed  = rand_seed();
                b.known = 1'b0;
                b.chk   = '0;
                send_beat(b);
                sent++;
            end
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (checksum_q.size() == 0) begin
                $display("%0t: unexpected checksum: expected none, got %h", $time, o_checksum);
                n_err++;
            end else begin
                exp_chk = checksum_q.pop_front();
                if (o_checksum !== exp_chk) begin
                    $display("%0t: checksum mismatch: expected %h, got %h",
                             $time, exp_chk, o_checksum);
                    n_err++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d checksums outstanding",
                     $time, checksum_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            send_beat(dir_tab[r]);
        end
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            run_packets(PHASE_ITEMS);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_err == 0 && checksum_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
